// ----- design/bounded_byte_deque_unit_assert.svh -----
// Assertion macros used by the deque RTL.
`ifndef BOUNDED_BYTE_DEQUE_UNIT_ASSERT_SVH
`define BOUNDED_BYTE_DEQUE_UNIT_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define BBD_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define BBD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/bbd_pkg.sv -----
package bbd_pkg;

  // Fixed field widths of the command and response channels
  localparam int unsigned CMD_W    = 4;
  localparam int unsigned VALUE_W  = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned DOUT_W   = 8;
  localparam int unsigned FILL_W   = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT    = 4'd0,
    CMD_PUSH_BACK     = 4'd1,
    CMD_POP_FRONT     = 4'd2,
    CMD_POP_BACK      = 4'd3,
    CMD_PEEK_FRONT    = 4'd4,
    CMD_PEEK_BACK     = 4'd5,
    CMD_REPLACE_FRONT = 4'd6,
    CMD_REPLACE_BACK  = 4'd7,
    CMD_CLEAR         = 4'd8,
    CMD_QUERY         = 4'd9
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } state_e;

endpackage

// ----- design/bbd_cmd_if.sv -----
interface bbd_cmd_if;
  import bbd_pkg::*;

  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output command, output value, input ready);
  modport sink (input valid, input command, input value, output ready);
endinterface

// ----- design/bbd_rsp_if.sv -----
interface bbd_rsp_if;
  import bbd_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [DOUT_W-1:0]   data_out;
  logic [FILL_W-1:0]   fill_count;
  logic                is_empty;

  modport source (output valid, output status, output data_out, output fill_count,
                  output is_empty, input ready);
  modport sink (input valid, input status, input data_out, input fill_count,
                input is_empty, output ready);
endinterface

// ----- design/bounded_byte_deque_unit.sv -----
// Push, replace, clear, query, and any command refused on a full or empty deque:
// result valid in the cycle after the command transfer.
// Pop and peek on a non-empty deque: result valid after the synchronous read of the
// entry memory into its read register, then the response register (state S_READ).
// Throughput: one command per cycle while the response side keeps up; a read stalls the next command.
// Reset (async, active low) empties the deque at once; entry memory is not cleared.
module bounded_byte_deque_unit #(
  parameter int unsigned CAPACITY   = 8,
  parameter int unsigned DATA_WIDTH = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  bbd_cmd_if.sink   cmd_i,
  bbd_rsp_if.source rsp_o
);
  import bbd_pkg::*;

  localparam int unsigned IDX_W  = $clog2(CAPACITY);
  localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
  localparam int unsigned SUM_W  = CNT_W + 1;
  localparam int unsigned COPY_W = (DATA_WIDTH < VALUE_W) ? DATA_WIDTH : VALUE_W;

  // Entry memory with a registered read
  logic [DATA_WIDTH-1:0] mem_q [CAPACITY];
  logic [DATA_WIDTH-1:0] rd_data_q;
  logic                  mem_we;
  logic                  mem_re;
  logic [IDX_W-1:0]      mem_addr;
  logic [DATA_WIDTH-1:0] wr_data;

  // Pointer, count and control state
  state_e           state_q, state_d;
  logic [IDX_W-1:0] head_q, head_d;
  logic [CNT_W-1:0] count_q, count_d;

  // Response register
  logic              out_valid_q, out_valid_d;
  status_e           status_q, status_d;
  logic [DOUT_W-1:0] dout_q, dout_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic              empty_q, empty_d;

  logic             cmd_xfer;
  logic             is_full;
  logic             is_none;
  logic [IDX_W-1:0] head_dec;
  logic [IDX_W-1:0] head_inc;
  logic [SUM_W-1:0] tail_sum;
  logic [SUM_W-1:0] back_sum;
  logic [IDX_W-1:0] tail_slot;
  logic [IDX_W-1:0] back_slot;
  cmd_e             cmd;

  assign cmd     = cmd_e'(cmd_i.command);
  assign is_full = (count_q == CNT_W'(CAPACITY));
  assign is_none = (count_q == '0);
  assign wr_data = DATA_WIDTH'(cmd_i.value[COPY_W-1:0]);

  assign cmd_i.ready = (state_q == S_IDLE) && (!out_valid_q || rsp_o.ready);
  assign cmd_xfer    = cmd_i.valid && cmd_i.ready;

  // Wrap end slots with one compare and subtract
  assign head_dec = (head_q == '0) ? IDX_W'(CAPACITY - 1) : head_q - 1'b1;
  assign head_inc = (head_q == IDX_W'(CAPACITY - 1)) ? '0 : head_q + 1'b1;
  assign tail_sum = SUM_W'(head_q) + SUM_W'(count_q);
  assign back_sum = tail_sum - 1'b1;
  assign tail_slot = (tail_sum >= SUM_W'(CAPACITY)) ?
                     IDX_W'(tail_sum - SUM_W'(CAPACITY)) : IDX_W'(tail_sum);
  assign back_slot = (back_sum >= SUM_W'(CAPACITY)) ?
                     IDX_W'(back_sum - SUM_W'(CAPACITY)) : IDX_W'(back_sum);

  // Decode the command, drive the memory port and the response
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    status_d    = status_q;
    dout_d      = dout_q;
    fill_d      = fill_q;
    empty_d     = empty_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_addr    = head_q;

    case (state_q)
      S_IDLE: begin
        if (cmd_xfer) begin
          status_d = ST_OK;
          dout_d   = '0;
          case (cmd)
            CMD_PUSH_FRONT: begin
              if (is_full) begin
                status_d = ST_FULL;
              end else begin
                mem_we   = 1'b1;
                mem_addr = head_dec;
                head_d   = head_dec;
                count_d  = count_q + 1'b1;
              end
            end
            CMD_PUSH_BACK: begin
              if (is_full) begin
                status_d = ST_FULL;
              end else begin
                mem_we   = 1'b1;
                mem_addr = tail_slot;
                count_d  = count_q + 1'b1;
              end
            end
            CMD_POP_FRONT, CMD_PEEK_FRONT: begin
              if (is_none) begin
                status_d = ST_EMPTY;
              end else begin
                mem_re   = 1'b1;
                mem_addr = head_q;
                if (cmd == CMD_POP_FRONT) begin
                  head_d  = head_inc;
                  count_d = count_q - 1'b1;
                end
              end
            end
            CMD_POP_BACK, CMD_PEEK_BACK: begin
              if (is_none) begin
                status_d = ST_EMPTY;
              end else begin
                mem_re   = 1'b1;
                mem_addr = back_slot;
                if (cmd == CMD_POP_BACK) begin
                  count_d = count_q - 1'b1;
                end
              end
            end
            CMD_REPLACE_FRONT: begin
              if (is_none) begin
                status_d = ST_EMPTY;
              end else begin
                mem_we   = 1'b1;
                mem_addr = head_q;
              end
            end
            CMD_REPLACE_BACK: begin
              if (is_none) begin
                status_d = ST_EMPTY;
              end else begin
                mem_we   = 1'b1;
                mem_addr = back_slot;
              end
            end
            CMD_CLEAR: begin
              head_d  = '0;
              count_d = '0;
            end
            default: begin
              // query and unused codes leave the state alone
            end
          endcase
          fill_d  = FILL_W'(count_d);
          empty_d = (count_d == '0);
          // hold the response until read data returns
          if (mem_re) begin
            state_d = S_READ;
          end else begin
            out_valid_d = 1'b1;
          end
        end
      end
      S_READ: begin
        // response register is free here: load the read data
        out_valid_d = 1'b1;
        dout_d      = DOUT_W'(rd_data_q[COPY_W-1:0]);
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Entry memory: write and registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= wr_data;
    end
    if (mem_re) begin
      rd_data_q <= mem_q[mem_addr];
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Response payload
  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    dout_q   <= dout_d;
    fill_q   <= fill_d;
    empty_q  <= empty_d;
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.status     = status_q;
  assign rsp_o.data_out   = dout_q;
  assign rsp_o.fill_count = fill_q;
  assign rsp_o.is_empty   = empty_q;

`include "bounded_byte_deque_unit_assert.svh"

  `BBD_ASSERT_SAME(a_count_bound, clk_i, rst_ni, 1'b1,
                   count_q <= CNT_W'(CAPACITY), "count above capacity")
  `BBD_ASSERT_NEXT(a_read_completes, clk_i, rst_ni, state_q == S_READ,
                   out_valid_q && state_q == S_IDLE, "read did not complete")
  `BBD_ASSERT_NEXT(a_full_push, clk_i, rst_ni,
                   cmd_xfer && is_full && (cmd == CMD_PUSH_FRONT || cmd == CMD_PUSH_BACK),
                   out_valid_q && status_q == ST_FULL && $stable(head_q) && $stable(count_q),
                   "push on full deque changed state")
  `BBD_ASSERT_SAME(a_read_slot_free, clk_i, rst_ni, state_q == S_READ,
                   !out_valid_q, "response register busy during read")

endmodule

// ----- test/bbd_deque_checker.sv -----
module bbd_deque_checker
  import bbd_pkg::*;
#(
  parameter int unsigned DEPTH = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bbd_cmd_if          cmd_i,
  bbd_rsp_if          rsp_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    status_e             status;
    logic [DOUT_W-1:0]   data_out;
    logic [FILL_W-1:0]   fill_count;
    logic                is_empty;
  } deque_rsp_t;

  // Shadow copy of the deque contents
  logic [VALUE_W-1:0] slot_mem [DEPTH];
  int unsigned        front_slot;
  int unsigned        stored_count;
  deque_rsp_t         rsp_expected_q [$];

  // Apply one command to the shadow deque and return its response
  task automatic predict_deque_response(input logic [CMD_W-1:0] code,
                                        input logic [VALUE_W-1:0] val,
                                        output deque_rsp_t rsp);
    int unsigned back_slot;
    back_slot = (front_slot + stored_count + DEPTH - 1) % DEPTH;
    rsp.status = ST_OK;
    rsp.data_out = '0;
    case (code)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (stored_count >= DEPTH) begin
          rsp.status = ST_FULL;
        end else if (code == CMD_PUSH_FRONT) begin
          front_slot = (front_slot + DEPTH - 1) % DEPTH;
          slot_mem[front_slot] = val;
          stored_count++;
        end else begin
          slot_mem[(front_slot + stored_count) % DEPTH] = val;
          stored_count++;
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK, CMD_PEEK_FRONT, CMD_PEEK_BACK,
      CMD_REPLACE_FRONT, CMD_REPLACE_BACK: begin
        if (stored_count == 0) begin
          rsp.status = ST_EMPTY;
        end else begin
          case (code)
            CMD_POP_FRONT: begin
              rsp.data_out = slot_mem[front_slot];
              front_slot = (front_slot + 1) % DEPTH;
              stored_count--;
            end
            CMD_POP_BACK: begin
              rsp.data_out = slot_mem[back_slot];
              stored_count--;
            end
            CMD_PEEK_FRONT:    rsp.data_out = slot_mem[front_slot];
            CMD_PEEK_BACK:     rsp.data_out = slot_mem[back_slot];
            CMD_REPLACE_FRONT: slot_mem[front_slot] = val;
            default:           slot_mem[back_slot] = val;
          endcase
        end
      end
      CMD_CLEAR: begin
        front_slot = 0;
        stored_count = 0;
      end
      // Query and undefined codes leave the deque alone
      default: ;
    endcase
    rsp.fill_count = stored_count[FILL_W-1:0];
    rsp.is_empty = (stored_count == 0);
  endtask

  // Check each response transfer, then predict each command transfer
  always @(posedge clk_i or negedge rst_ni) begin
    deque_rsp_t exp_rsp;
    deque_rsp_t new_rsp;
    if (!rst_ni) begin
      front_slot = 0;
      stored_count = 0;
      rsp_expected_q.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        if (rsp_expected_q.size() == 0) begin
          if (fail_count_o < REPORT_LIMIT)
            $display("%0t: response with none expected: status %0d data %0h fill %0d empty %0b",
                     $realtime, rsp_i.status, rsp_i.data_out, rsp_i.fill_count,
                     rsp_i.is_empty);
          fail_count_o++;
        end else begin
          exp_rsp = rsp_expected_q.pop_front();
          if (rsp_i.status !== exp_rsp.status || rsp_i.data_out !== exp_rsp.data_out ||
              rsp_i.fill_count !== exp_rsp.fill_count ||
              rsp_i.is_empty !== exp_rsp.is_empty) begin
            if (fail_count_o < REPORT_LIMIT)
              $display("%0t: mismatch exp status %0d data %0h fill %0d empty %0b, got status %0d data %0h fill %0d empty %0b",
                       $realtime, exp_rsp.status, exp_rsp.data_out, exp_rsp.fill_count,
                       exp_rsp.is_empty, rsp_i.status, rsp_i.data_out,
                       rsp_i.fill_count, rsp_i.is_empty);
            fail_count_o++;
          end
        end
      end
      if (cmd_i.valid && cmd_i.ready) begin
        predict_deque_response(cmd_i.command, cmd_i.value, new_rsp);
        rsp_expected_q.push_back(new_rsp);
      end
      pending_o = rsp_expected_q.size();
    end
  end

endmodule

// ----- test/bounded_byte_deque_unit_tb.sv -----
module bounded_byte_deque_unit_tb;
  import bbd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH            = 8;
  localparam int unsigned RANDOM_ITEMS     = 1500;
  localparam int unsigned LONG_HOLD_CYCLES = 200;
  localparam int unsigned MAX_GAP          = 15;
  localparam logic [CMD_W-1:0] CMD_UNDEF_FIRST = 4'd10;
  localparam logic [CMD_W-1:0] CMD_UNDEF_LAST  = 4'd15;

  logic        clk_i;
  logic        rst_ni;
  bit          send_no_idle;
  bit          recv_no_idle;
  bit          hold_request;
  int unsigned fail_count;
  int unsigned pending;

  bbd_cmd_if cmd_if ();
  bbd_rsp_if rsp_if ();

  bounded_byte_deque_unit #(
    .CAPACITY  (DEPTH),
    .DATA_WIDTH(VALUE_W)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd_if),
    .rsp_o (rsp_if)
  );

  bbd_deque_checker #(
    .DEPTH(DEPTH)
  ) u_deque_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_if),
    .rsp_i       (rsp_if),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Abort a hung run
  initial begin
    #1_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Drive one command after a random gap and hold it until the transfer
  task automatic send_command(input logic [CMD_W-1:0] code, input logic [VALUE_W-1:0] val);
    int unsigned gap;
    @(negedge clk_i);
    gap = send_no_idle ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      cmd_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cmd_if.command = code;
    cmd_if.value = val;
    cmd_if.valid = 1'b1;
    do @(posedge clk_i); while (!cmd_if.ready);
  endtask

  // Drop valid and hold until every expected response has arrived
  task automatic wait_for_drain();
    @(negedge clk_i);
    cmd_if.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // Response side: random stall per transfer, one long hold on request
  initial begin
    int unsigned stall;
    bit          hold_done;
    rsp_if.ready = 1'b0;
    hold_done = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      stall = recv_no_idle ? 0 : $urandom_range(0, MAX_GAP);
      if (hold_request && !hold_done) begin
        stall = LONG_HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (stall > 0) begin
        rsp_if.ready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      rsp_if.ready = 1'b1;
      do @(posedge clk_i); while (!rsp_if.valid);
    end
  end

  initial begin
    int unsigned      pick;
    int unsigned      push_pct;
    logic [CMD_W-1:0] code;
    rst_ni = 1'b0;
    cmd_if.valid = 1'b0;
    cmd_if.command = CMD_QUERY;
    cmd_if.value = '0;
    send_no_idle = 1'b0;
    recv_no_idle = 1'b0;
    hold_request = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Every access on an empty deque, clear, query and undefined codes
    send_command(CMD_POP_FRONT, 8'h00);
    send_command(CMD_POP_BACK, 8'h00);
    send_command(CMD_PEEK_FRONT, 8'h00);
    send_command(CMD_PEEK_BACK, 8'h00);
    send_command(CMD_REPLACE_FRONT, 8'hFF);
    send_command(CMD_REPLACE_BACK, 8'h00);
    send_command(CMD_CLEAR, 8'h00);
    send_command(CMD_QUERY, 8'hFF);
    send_command(CMD_UNDEF_FIRST, 8'h00);
    send_command(CMD_UNDEF_LAST, 8'hFF);
    // Fill from both ends, wrapping the head below slot zero
    send_command(CMD_PUSH_BACK, 8'h00);
    send_command(CMD_PUSH_FRONT, 8'hFF);
    send_command(CMD_PUSH_BACK, 8'h55);
    send_command(CMD_PUSH_FRONT, 8'hAA);
    send_command(CMD_PUSH_BACK, 8'h01);
    send_command(CMD_PUSH_FRONT, 8'h80);
    send_command(CMD_PUSH_BACK, 8'h7F);
    send_command(CMD_PUSH_FRONT, 8'hFE);
    // Pushes onto a full deque
    send_command(CMD_PUSH_FRONT, 8'h11);
    send_command(CMD_PUSH_BACK, 8'h22);
    // End accesses on a full deque
    send_command(CMD_PEEK_FRONT, 8'h00);
    send_command(CMD_PEEK_BACK, 8'h00);
    send_command(CMD_REPLACE_FRONT, 8'hC3);
    send_command(CMD_REPLACE_BACK, 8'h3C);
    send_command(CMD_POP_FRONT, 8'h00);
    send_command(CMD_POP_BACK, 8'h00);
    send_command(CMD_CLEAR, 8'h00);
    wait_for_drain();

    // Random traffic: alternate filling and draining phases
    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 300) begin
        send_no_idle = 1'b1;
        hold_request = 1'b1;
      end
      if (i == 360) send_no_idle = 1'b0;
      if (i == 700) wait_for_drain();
      if (i == 1000) begin
        send_no_idle = 1'b1;
        recv_no_idle = 1'b1;
      end
      if (i == 1100) begin
        send_no_idle = 1'b0;
        recv_no_idle = 1'b0;
      end
      push_pct = ((i / 60) % 2 == 0) ? 70 : 20;
      pick = $urandom_range(0, 99);
      if (pick < push_pct)
        code = $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
      else if (pick < 94)
        code = CMD_W'($urandom_range(CMD_POP_FRONT, CMD_REPLACE_BACK));
      else if (pick < 96)
        code = CMD_CLEAR;
      else
        code = CMD_W'($urandom_range(CMD_QUERY, CMD_UNDEF_LAST));
      send_command(code, VALUE_W'($urandom_range(0, 255)));
    end

    wait_for_drain();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
